// ===== sv/gsa_pkg.sv =====
// Shared types and constants for the generational slot allocator.
package gsa_pkg;

	// Field widths of the stream payloads
	localparam int CMD_W = 2;
	localparam int HIDX_W = 8;
	localparam int GEN_W = 32;
	localparam int STS_W = 2;
	localparam int OIDX_W = 4;
	localparam int CFG_W = 5;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

	// Status codes
	localparam logic [STS_W-1:0] STS_OK = 2'd0;
	localparam logic [STS_W-1:0] STS_FULL = 2'd1;
	localparam logic [STS_W-1:0] STS_INVALID = 2'd2;

	// Register map (word index taken from paddr[2])
	localparam logic REG_SLOTS_IN_USE = 1'b0;
	localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 5'd16;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} gsa_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic launch;   // take the item, look up the slot, start the memory read
		logic commit;   // finish the item and load the output register
	} gsa_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free; // output register can take a result this cycle
	} gsa_stat_t;

endpackage

// ===== sv/gsa_ctrl.sv =====
// Sequencer for the slot allocator: lookup cycle, then execute cycle.
module gsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gsa_pkg::gsa_stat_t stat,
	output gsa_pkg::gsa_cmd_t  cmd
);
	import gsa_pkg::*;

	gsa_state_t state_q;
	gsa_state_t state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd.launch = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.launch = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/gsa_datapath.sv =====
// Slot state, generation memory, first-free search and result register.
module gsa_datapath #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gsa_pkg::gsa_cmd_t          cmd,
	output gsa_pkg::gsa_stat_t         stat,
	input  logic [gsa_pkg::CMD_W-1:0]  in_command,
	input  logic [gsa_pkg::HIDX_W-1:0] in_handle_index,
	input  logic [gsa_pkg::GEN_W-1:0]  in_handle_generation,
	input  logic [gsa_pkg::CFG_W-1:0]  slots_in_use,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [gsa_pkg::STS_W-1:0]  out_status,
	output logic [gsa_pkg::OIDX_W-1:0] out_slot_index,
	output logic [gsa_pkg::GEN_W-1:0]  out_slot_generation
);
	import gsa_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CMP_W = 9;

	logic [SLOT_COUNT-1:0] alive_q;
	logic [SLOT_COUNT-1:0] written_q;
	logic [GEN_W-1:0]      gen_mem [SLOT_COUNT];

	logic [SLOT_COUNT-1:0] eligible;
	logic                  found;
	logic [IDX_W-1:0]      pick;
	logic                  in_range;
	logic [IDX_W-1:0]      rd_addr;

	// Lookup stage registers
	logic [CMD_W-1:0] cmd_s1;
	logic [GEN_W-1:0] hgen_s1;
	logic             in_range_s1;
	logic             found_s1;
	logic [IDX_W-1:0] addr_s1;
	logic [GEN_W-1:0] rd_gen_s1;
	logic             rd_written_s1;

	// Execute stage logic
	logic [GEN_W-1:0]  gen_cur;
	logic              handle_ok;
	logic [STS_W-1:0]  res_status;
	logic [HIDX_W-1:0] res_idx_ext;
	logic [GEN_W-1:0]  res_gen;
	logic              set_alive;
	logic              clr_alive;

	// Output register
	logic              out_valid_q;
	logic [STS_W-1:0]  out_status_q;
	logic [OIDX_W-1:0] out_idx_q;
	logic [GEN_W-1:0]  out_gen_q;

	// Free slots below the active capacity
	for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_elig
		assign eligible[g] = !alive_q[g] &&
			(CMP_W'(g) < CMP_W'(slots_in_use));
	end

	// Priority encoder: lowest eligible slot wins
	always_comb begin
		found = 1'b0;
		pick = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (eligible[i]) begin
				found = 1'b1;
				pick = IDX_W'(i);
			end
		end
	end

	// Handle index must lie below both the register and the pool size
	assign in_range = (CMP_W'(in_handle_index) < CMP_W'(slots_in_use)) &&
		(CMP_W'(in_handle_index) < CMP_W'(SLOT_COUNT));

	always_comb begin
		if (in_command == CMD_ALLOC) begin
			rd_addr = pick;
		end else if (in_range) begin
			rd_addr = in_handle_index[IDX_W-1:0];
		end else begin
			rd_addr = '0;
		end
	end

	// Lookup registers and registered memory read
	always_ff @(posedge clk) begin
		if (cmd.launch) begin
			cmd_s1 <= in_command;
			hgen_s1 <= in_handle_generation;
			in_range_s1 <= in_range;
			found_s1 <= found;
			addr_s1 <= rd_addr;
			rd_gen_s1 <= gen_mem[rd_addr];
			rd_written_s1 <= written_q[rd_addr];
		end
	end

	// Never-written entries read as generation zero
	assign gen_cur = rd_written_s1 ? rd_gen_s1 : '0;
	assign handle_ok = in_range_s1 && alive_q[addr_s1] && (gen_cur == hgen_s1);

	// Command evaluation
	always_comb begin
		res_status = STS_INVALID;
		res_idx_ext = '0;
		res_gen = '0;
		set_alive = 1'b0;
		clr_alive = 1'b0;
		case (cmd_s1)
			CMD_ALLOC: begin
				if (found_s1) begin
					res_status = STS_OK;
					res_idx_ext = HIDX_W'(addr_s1);
					res_gen = gen_cur;
					set_alive = 1'b1;
				end else begin
					res_status = STS_FULL;
				end
			end
			CMD_FREE: begin
				if (handle_ok) begin
					res_status = STS_OK;
					clr_alive = 1'b1;
				end
			end
			CMD_CHECK: begin
				if (handle_ok) begin
					res_status = STS_OK;
				end
			end
			default: begin
				res_status = STS_INVALID;
			end
		endcase
	end

	// Generation write-back on a valid free
	always_ff @(posedge clk) begin
		if (cmd.commit && clr_alive) begin
			gen_mem[addr_s1] <= gen_cur + GEN_W'(1);
		end
	end

	// Alive and written bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '0;
			written_q <= '0;
		end else if (cmd.commit) begin
			if (set_alive) begin
				alive_q[addr_s1] <= 1'b1;
			end
			if (clr_alive) begin
				alive_q[addr_s1] <= 1'b0;
				written_q[addr_s1] <= 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status_q <= res_status;
			out_idx_q <= res_idx_ext[OIDX_W-1:0];
			out_gen_q <= res_gen;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_status = out_status_q;
	assign out_slot_index = out_idx_q;
	assign out_slot_generation = out_gen_q;

endmodule

// ===== sv/generational_slot_allocator_unit.sv =====
// Top level of the generational slot allocator: stream ports, APB register, assertions.
// Pool of SLOT_COUNT handles, each slot an alive bit and a 32-bit generation.
// Allocate (0) hands out the lowest free slot below slots_in_use, free (1)
// retires a live handle and bumps its generation, check (2) reports whether a
// handle is live and current. On accept, the first-free priority encoder or
// the handle index addresses the generation memory, whose read data is
// registered; in the execute state the handle is compared, the memory is
// written back and the result register is loaded. The execute state waits
// while the result register holds an untaken transaction. One result per
// command. slots_in_use sits at byte address 0 and resets to 16; write it
// only while the pool is idle. No clearing pass follows reset.
module generational_slot_allocator_unit #(
	parameter int SLOT_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // command[1:0], handle_index[9:2], handle_generation[41:10], zero
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // status[1:0], slot_index[5:2], slot_generation[37:6], zero
);
	import gsa_pkg::*;

	logic [CFG_W-1:0] slots_in_use_q;
	gsa_cmd_t         cmd;
	gsa_stat_t        stat;
	logic [STS_W-1:0]  out_status;
	logic [OIDX_W-1:0] out_slot_index;
	logic [GEN_W-1:0]  out_slot_generation;

	// Configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= SLOTS_IN_USE_RST;
		end else if (psel && penable && pwrite && pready &&
			(paddr[2] == REG_SLOTS_IN_USE)) begin
			slots_in_use_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_SLOTS_IN_USE) ? 32'(slots_in_use_q) : '0;

	gsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gsa_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.stat                 (stat),
		.in_command           (s_tdata[1:0]),
		.in_handle_index      (s_tdata[9:2]),
		.in_handle_generation (s_tdata[41:10]),
		.slots_in_use         (slots_in_use_q),
		.out_valid            (m_tvalid),
		.out_ready            (m_tready),
		.out_status           (out_status),
		.out_slot_index       (out_slot_index),
		.out_slot_generation  (out_slot_generation)
	);

	assign m_tdata = {2'b00, out_slot_generation, out_slot_index, out_status};

	// One command in flight: no accept in the cycle after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("command accepted while previous one still executing");

	// Failed results (pool full or invalid) carry zero index and generation
	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[1:0] == STS_FULL || m_tdata[1:0] == STS_INVALID))
		|-> (m_tdata[37:2] == '0))
		else $error("non-zero payload on failed result");

	// Only the defined status codes appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == STS_OK || m_tdata[1:0] == STS_FULL ||
			m_tdata[1:0] == STS_INVALID))
		else $error("undefined status code");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking stream and register testbench for the generational slot allocator unit.
module testbench;
	import gsa_pkg::*;

	localparam int POOL_SLOTS = 16;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_PCT = 21;
	// transactions in this window are never held back on either side
	localparam int CALM_FIRST = 300;
	localparam int CALM_LAST = 420;
	localparam int PHASES = 10;
	localparam int RANDOM_PER_PHASE = 63;
	localparam int PHASE_CAPS [PHASES] = '{16, 1, 31, 0, 7, 17, 4, 16, 2, 12};
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [HIDX_W-1:0] idx;
		logic [GEN_W-1:0]  gen;
	} pool_req_t;

	typedef struct packed {
		logic [STS_W-1:0]  status;
		logic [OIDX_W-1:0] idx;
		logic [GEN_W-1:0]  gen;
	} pool_resp_t;

	typedef struct packed {
		logic [CFG_W-1:0]                  slots_in_use;
		logic [POOL_SLOTS-1:0]             alive;
		logic [POOL_SLOTS-1:0][GEN_W-1:0]  gens;
	} pool_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // command[1:0], handle_index[9:2], handle_generation[41:10], zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // status[1:0], slot_index[5:2], slot_generation[37:6], zero

	pool_req_t   cmd_q [$];
	pool_resp_t  expected_q [$];
	pool_state_t plan_st;        // state as the command list is built
	pool_state_t live_st;        // state as commands are accepted
	pool_req_t   in_flight_req;
	pool_resp_t  accepted_resp;
	pool_resp_t  got_resp;
	pool_resp_t  want_resp;
	int unsigned queued_cnt = 0;
	int unsigned sent_cnt = 0;
	int unsigned got_cnt = 0;
	int unsigned err_cnt = 0;
	int unsigned cfg_cnt = 0;
	int unsigned ok_cnt = 0;
	int unsigned full_cnt = 0;
	int unsigned invalid_cnt = 0;

	generational_slot_allocator_unit #(
		.SLOT_COUNT(POOL_SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// Pool model
	function automatic pool_state_t pool_reset();
		pool_state_t st;
		st.slots_in_use = SLOTS_IN_USE_RST;
		st.alive = '0;
		st.gens = '0;
		return st;
	endfunction

	function automatic int unsigned pool_capacity(input pool_state_t st);
		return (int'(st.slots_in_use) < POOL_SLOTS) ? int'(st.slots_in_use) : POOL_SLOTS;
	endfunction

	function automatic logic handle_live(input pool_state_t st, input int unsigned idx,
			input logic [GEN_W-1:0] gen);
		return idx < pool_capacity(st) && st.alive[idx] && st.gens[idx] == gen;
	endfunction

	function automatic pool_resp_t pool_step(inout pool_state_t st, input pool_req_t rq);
		pool_resp_t  rs;
		int unsigned cap;
		int unsigned hidx;
		logic        found;
		rs.status = STS_INVALID;
		rs.idx = '0;
		rs.gen = '0;
		cap = pool_capacity(st);
		hidx = rq.idx;
		found = 1'b0;
		case (rq.cmd)
			CMD_ALLOC: begin
				rs.status = STS_FULL;
				// lowest free slot within the active capacity
				for (int i = 0; i < POOL_SLOTS; i++) begin
					if (!found && i < cap && !st.alive[i]) begin
						found = 1'b1;
						st.alive[i] = 1'b1;
						rs.status = STS_OK;
						rs.idx = OIDX_W'(i);
						rs.gen = st.gens[i];
					end
				end
			end
			CMD_FREE: begin
				if (handle_live(st, hidx, rq.gen)) begin
					st.alive[hidx] = 1'b0;
					st.gens[hidx] = st.gens[hidx] + 1'b1;
					rs.status = STS_OK;
				end
			end
			CMD_CHECK: begin
				if (handle_live(st, hidx, rq.gen))
					rs.status = STS_OK;
			end
			default: rs.status = STS_INVALID;
		endcase
		return rs;
	endfunction

	function automatic void log_error(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS)
			$display("mismatch: %s", msg);
	endfunction

	// Command list building
	task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [HIDX_W-1:0] idx,
			input logic [GEN_W-1:0] gen);
		pool_req_t rq;
		rq.cmd = cmd;
		rq.idx = idx;
		rq.gen = gen;
		cmd_q.push_back(rq);
		void'(pool_step(plan_st, rq));
		queued_cnt++;
	endtask

	task automatic queue_random(input int n);
		int unsigned r;
		int unsigned cap;
		int unsigned pick;
		int unsigned live [$];
		pool_req_t   rq;
		repeat (n) begin
			cap = pool_capacity(plan_st);
			live.delete();
			for (int i = 0; i < POOL_SLOTS; i++)
				if (i < cap && plan_st.alive[i])
					live.push_back(i);
			r = $urandom_range(0, 99);
			// handle fields are don't-care on allocate, so fill them with noise
			rq.cmd = CMD_ALLOC;
			rq.idx = HIDX_W'($urandom);
			rq.gen = $urandom;
			if (r >= 36 && r < 88 && live.size() != 0) begin
				pick = live[$urandom_range(0, live.size() - 1)];
				rq.cmd = (r < 62 || (r >= 80 && r[0])) ? CMD_FREE : CMD_CHECK;
				rq.idx = HIDX_W'(pick);
				rq.gen = plan_st.gens[pick];
				// stale handle: right slot, wrong generation
				if (r >= 80)
					rq.gen = r[1] ? rq.gen + 1'b1 : rq.gen - 1'b1;
			end else if (r >= 88) begin
				rq.cmd = CMD_W'($urandom_range(0, 3));
				rq.idx = r[0] ? HIDX_W'($urandom_range(0, 31)) : HIDX_W'($urandom);
				rq.gen = r[1] ? GEN_W'($urandom_range(0, 3)) : GEN_W'($urandom);
			end
			push_req(rq.cmd, rq.idx, rq.gen);
		end
	endtask

	task automatic wait_idle();
		while (got_cnt != queued_cnt)
			@(posedge clk);
	endtask

	// APB write of the capacity register, then read it back
	task automatic write_slots_in_use(input logic [CFG_W-1:0] v);
		logic [31:0] rd;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_SLOTS_IN_USE, 2'b00};
		pwdata <= ($urandom & 32'hFFFF_FFE0) | 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		live_st.slots_in_use = v;
		plan_st.slots_in_use = v;
		cfg_cnt++;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd[CFG_W-1:0] !== v)
			log_error($sformatf("slots_in_use readback expected %0d, got %0d", v, rd[CFG_W-1:0]));
	endtask

	// Command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				accepted_resp = pool_step(live_st, in_flight_req);
				expected_q.push_back(accepted_resp);
				sent_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (cmd_q.size() != 0 && ((sent_cnt >= CALM_FIRST && sent_cnt < CALM_LAST) ||
						$urandom_range(0, 99) >= IDLE_PCT)) begin
					in_flight_req = cmd_q.pop_front();
					s_tdata <= {6'd0, in_flight_req.gen, in_flight_req.idx, in_flight_req.cmd};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_resp.status = m_tdata[1:0];
				got_resp.idx = m_tdata[5:2];
				got_resp.gen = m_tdata[37:6];
				case (got_resp.status)
					STS_OK:      ok_cnt++;
					STS_FULL:    full_cnt++;
					STS_INVALID: invalid_cnt++;
					default: ;
				endcase
				if (expected_q.size() == 0) begin
					log_error($sformatf("result with nothing expected: status %0d slot %0d gen %h",
						got_resp.status, got_resp.idx, got_resp.gen));
				end else begin
					want_resp = expected_q.pop_front();
					got_cnt++;
					if (got_resp.status !== want_resp.status || got_resp.idx !== want_resp.idx ||
							got_resp.gen !== want_resp.gen)
						log_error($sformatf(
							"result %0d: expected st %0d slot %0d gen %h, got st %0d slot %0d gen %h",
							got_cnt, want_resp.status, want_resp.idx, want_resp.gen,
							got_resp.status, got_resp.idx, got_resp.gen));
				end
			end
			m_tready <= (got_cnt >= CALM_FIRST && got_cnt < CALM_LAST) ||
				$urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("timeout after %0d of %0d results", got_cnt, queued_cnt);
		$display("status: fail");
		$finish;
	end

	// Stimulus sequence
	initial begin
		logic [CFG_W-1:0] cap_v;
		plan_st = pool_reset();
		live_st = plan_st;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset capacity: free slot, first allocate, stale and out-of-range handles
		push_req(CMD_CHECK, 8'd0, 32'd0);
		push_req(CMD_FREE, 8'd0, 32'd0);
		push_req(CMD_ALLOC, 8'hFF, 32'hFFFF_FFFF);
		push_req(CMD_CHECK, 8'd0, 32'd0);
		push_req(CMD_CHECK, 8'd0, 32'd1);
		push_req(CMD_CHECK, 8'hFF, 32'hFFFF_FFFF);
		push_req(CMD_UNUSED, 8'd0, 32'd0);
		push_req(CMD_FREE, 8'd0, 32'd0);
		push_req(CMD_CHECK, 8'd0, 32'd0);
		push_req(CMD_ALLOC, 8'd0, 32'd0);
		push_req(CMD_ALLOC, 8'd0, 32'd0);
		push_req(CMD_ALLOC, 8'd0, 32'd0);
		push_req(CMD_FREE, 8'd15, 32'd0);
		push_req(CMD_FREE, 8'd1, 32'd0);
		push_req(CMD_ALLOC, 8'd0, 32'd0);
		wait_idle();

		// capacity lowered below a live slot: pool full, slot 2 out of range
		write_slots_in_use(5'd2);
		push_req(CMD_ALLOC, 8'd0, 32'd0);
		push_req(CMD_CHECK, 8'd2, 32'd0);
		push_req(CMD_FREE, 8'd2, 32'd0);
		push_req(CMD_CHECK, 8'd16, 32'd0);
		wait_idle();

		// capacity zero
		write_slots_in_use(5'd0);
		push_req(CMD_ALLOC, 8'd0, 32'd0);
		push_req(CMD_CHECK, 8'd0, 32'd1);
		push_req(CMD_FREE, 8'd0, 32'd1);
		wait_idle();

		// capacity above the slot count, live slot 2 usable again
		write_slots_in_use(5'd31);
		push_req(CMD_CHECK, 8'd2, 32'd0);
		push_req(CMD_ALLOC, 8'd0, 32'd0);
		push_req(CMD_FREE, 8'd2, 32'd0);
		wait_idle();

		// random phases, one capacity setting each
		for (int p = 0; p < PHASES; p++) begin
			cap_v = (p == 4 || p == 8) ? CFG_W'($urandom_range(0, 31)) : CFG_W'(PHASE_CAPS[p]);
			write_slots_in_use(cap_v);
			if (p == 2) begin
				// sender holds off mid-phase until the pipeline is empty
				queue_random(30);
				wait_idle();
				queue_random(RANDOM_PER_PHASE - 30);
			end else begin
				queue_random(RANDOM_PER_PHASE);
			end
			wait_idle();
		end

		wait_idle();
		repeat (16) @(posedge clk);
		if (expected_q.size() != 0)
			log_error($sformatf("%0d results never arrived", expected_q.size()));
		$display("summary: %0d commands checked across %0d capacity writes", sent_cnt, cfg_cnt);
		$display("summary: %0d success, %0d pool full, %0d invalid, %0d mismatches",
			ok_cnt, full_cnt, invalid_cnt, err_cnt);
		if (err_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/gsa_pkg.sv
sv/gsa_ctrl.sv
sv/gsa_datapath.sv
sv/generational_slot_allocator_unit.sv
tb/testbench.sv
